@@ hdl/tmcw_pkg.sv @@
package tmcw_pkg;

   localparam logic [15:0] BLANK_CELL   = 16'h0020;
   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  ATTR_RESET   = 8'h0F;

   // Command classes handed from front to back.
   typedef enum logic [1:0] {
      CMD_PUT,        // write a character cell, advance cursor
      CMD_NEWLINE,    // move to start of next line
      CMD_READ,       // read one cell, address in range
      CMD_READ_NONE   // read outside the screen, answers 0
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [4:0]   row;
      logic [6:0]   column;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_BLANK
   } state_type;

endpackage

@@ hdl/tmcw_ifs.sv @@
interface tmcw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_code;
   logic [4:0] read_row;
   logic [6:0] read_column;

   modport source (output valid, action, char_code, read_row, read_column, input ready);
   modport sink   (input valid, action, char_code, read_row, read_column, output ready);
endinterface

interface tmcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_value;
   logic [4:0]  cursor_row;
   logic [6:0]  cursor_column;
   logic        scrolled;

   modport source (output valid, cell_value, cursor_row, cursor_column, scrolled, input ready);
   modport sink   (input valid, cell_value, cursor_row, cursor_column, scrolled, output ready);
endinterface

interface tmcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_attribute;

   modport source (output valid, text_attribute, input ready);
   modport sink   (input valid, text_attribute, output ready);
endinterface

@@ hdl/tmcw_front.sv @@
module tmcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   tmcw_req_if.sink           req,
   input  logic               queue_full,
   input  logic               clearing,
   output logic               push,
   output tmcw_pkg::cmd_type  push_cmd
);

   logic in_range;

   assign req.ready = !queue_full && !clearing;
   assign push      = req.valid && req.ready;

   assign in_range = (32'(req.read_row) < ROWS) && (32'(req.read_column) < COLUMNS);

   always_comb begin
      push_cmd.char_code = req.char_code;
      push_cmd.row       = req.read_row;
      push_cmd.column    = req.read_column;
      if (req.action) begin
         push_cmd.kind = in_range ? tmcw_pkg::CMD_READ : tmcw_pkg::CMD_READ_NONE;
      end else if (req.char_code == tmcw_pkg::NEWLINE_CODE) begin
         push_cmd.kind = tmcw_pkg::CMD_NEWLINE;
      end else begin
         push_cmd.kind = tmcw_pkg::CMD_PUT;
      end
   end

endmodule

@@ hdl/tmcw_queue.sv @@
module tmcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tmcw_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output tmcw_pkg::cmd_type  head_cmd
);

   // two-entry command queue
   tmcw_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/tmcw_back.sv @@
module tmcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  tmcw_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic [7:0]         attribute,
   output logic               clearing,
   tmcw_rsp_if.source         rsp
);

   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   tmcw_pkg::state_type state_ff, state_in;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  base_ff, base_in;      // physical row of top line
   logic [ROW_W-1:0]  blank_row_ff, blank_row_in;
   logic [COL_W-1:0]  blank_cnt_ff, blank_cnt_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [15:0]       cells_ff [DEPTH];
   logic [15:0]       rd_data_ff;

   logic              out_valid_ff, out_valid_in;
   logic [15:0]       out_cell_ff, out_cell_in;
   logic [4:0]        out_row_ff, out_row_in;
   logic [6:0]        out_col_ff, out_col_in;
   logic              out_scr_ff, out_scr_in;

   logic              out_free, go, is_put, is_nl, adv, wrap, row_last, scroll;
   logic              clr_last, blank_last, out_load;
   logic [COL_W:0]    col_adv;
   logic [ROW_W-1:0]  lrow, prow, base_next;
   logic [COL_W-1:0]  lcol;
   logic [ROW_W:0]    psum;
   logic [ADDR_W-1:0] cell_addr, blank_addr, wr_addr;
   logic [15:0]       wr_data;
   logic              wr_en;

   assign out_free = !out_valid_ff || rsp.ready;
   assign go       = (state_ff == tmcw_pkg::ST_IDLE) && cmd_valid && out_free;
   assign is_put   = (cmd.kind == tmcw_pkg::CMD_PUT);
   assign is_nl    = (cmd.kind == tmcw_pkg::CMD_NEWLINE);
   assign adv      = go && (is_put || is_nl);

   assign col_adv  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign wrap     = is_nl || (col_adv == (COL_W+1)'(COLUMNS));
   assign row_last = (row_ff == ROW_W'(ROWS - 1));
   assign scroll   = adv && wrap && row_last;
   assign base_next = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);

   assign clr_last   = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign blank_last = (blank_cnt_ff == COL_W'(COLUMNS - 1));
   assign clearing   = (state_ff == tmcw_pkg::ST_CLEAR);

   // logical to physical address through the ring offset
   assign lrow = (cmd.kind == tmcw_pkg::CMD_READ) ? ROW_W'(cmd.row) : row_ff;
   assign lcol = (cmd.kind == tmcw_pkg::CMD_READ) ? COL_W'(cmd.column) : col_ff;
   assign psum = {1'b0, lrow} + {1'b0, base_ff};
   assign prow = (psum >= (ROW_W+1)'(ROWS)) ? ROW_W'(psum - (ROW_W+1)'(ROWS)) : ROW_W'(psum);
   assign cell_addr  = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(lcol);
   assign blank_addr = ADDR_W'(blank_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(blank_cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmcw_pkg::ST_CLEAR: begin
            if (clr_last) state_in = tmcw_pkg::ST_IDLE;
         end
         tmcw_pkg::ST_IDLE: begin
            if (go && cmd.kind == tmcw_pkg::CMD_READ) begin
               state_in = tmcw_pkg::ST_READ;
            end else if (scroll) begin
               state_in = tmcw_pkg::ST_BLANK;
            end
         end
         tmcw_pkg::ST_READ: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
         tmcw_pkg::ST_BLANK: begin
            if (blank_last) state_in = tmcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cell_addr;
      wr_data  = tmcw_pkg::BLANK_CELL;
      cmd_pop  = 1'b0;
      out_load = 1'b0;
      out_cell_in = 16'd0;
      out_scr_in  = 1'b0;
      case (state_ff)
         tmcw_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
         end
         tmcw_pkg::ST_IDLE: begin
            cmd_pop = go;
            if (go && cmd.kind != tmcw_pkg::CMD_READ) begin
               out_load   = 1'b1;
               out_scr_in = scroll;
               if (is_put) begin
                  wr_en       = 1'b1;
                  wr_data     = {attribute, cmd.char_code};
                  out_cell_in = {attribute, cmd.char_code};
               end
            end
         end
         tmcw_pkg::ST_READ: begin
            out_load    = 1'b1;
            out_cell_in = rd_data_ff;
         end
         tmcw_pkg::ST_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = blank_addr;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // cursor, ring offset and sweep counters
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      blank_row_in = blank_row_ff;
      blank_cnt_in = blank_cnt_ff;
      clr_cnt_in   = clearing ? clr_cnt_ff + ADDR_W'(1) : clr_cnt_ff;
      if (adv) begin
         if (!wrap) begin
            col_in = COL_W'(col_adv);
         end else begin
            col_in = '0;
            if (row_last) begin
               base_in      = base_next;
               blank_row_in = base_ff;   // old top line becomes the bottom line
               blank_cnt_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
      end
      if (state_ff == tmcw_pkg::ST_BLANK) begin
         blank_cnt_in = blank_cnt_ff + COL_W'(1);
      end
      out_row_in   = 5'(row_in);
      out_col_in   = 7'(col_in);
      out_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcw_pkg::ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         blank_cnt_ff <= '0;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         blank_cnt_ff <= blank_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blank_row_ff <= blank_row_in;
      if (out_load) begin
         out_cell_ff <= out_cell_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_scr_ff  <= out_scr_in;
      end
   end

   // screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[cell_addr];
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.cell_value    = out_cell_ff;
   assign rsp.cursor_row    = out_row_ff;
   assign rsp.cursor_column = out_col_ff;
   assign rsp.scrolled      = out_scr_ff;

endmodule

@@ hdl/text_mode_console_writer.sv @@
// Text-mode console writer: a ROWS x COLUMNS screen of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor.
// req beat: action 0 puts char_code at the cursor (10 is newline), action 1
//   reads the cell at read_row/read_column. Every beat gives one rsp beat.
// rsp beat: cell_value, cursor_row, cursor_column after the beat, scrolled.
// csr beat: writes text_attribute (reset 0x0F); write it only while idle.
// A put or newline passes the command queue and then the rsp output register;
//   a read also passes the registered store read port before that register.
// While rsp is not stalled, the back end takes one put/newline per cycle; it
//   takes no new command during a read or while a scroll blanks the new bottom
//   line. Scrolling moves a ring offset, so no line is copied.
// A two-beat command queue sits between the front and the back end, so req
//   keeps being taken while a finished rsp beat waits for the receiver.
// Reset: synchronous; afterwards a clearing pass writes 0x0020 to all
//   ROWS*COLUMNS cells with req.ready low; csr beats are taken throughout.
// rsp stall: the output register holds; once the queue fills, req.ready drops.
module text_mode_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   tmcw_req_if.sink    req_bus,
   tmcw_rsp_if.source  rsp_bus,
   tmcw_csr_if.sink    csr_bus
);

   logic [7:0]        attr_ff, attr_in;

   logic              push, pop, queue_full, queue_not_empty, clearing;
   tmcw_pkg::cmd_type push_cmd, head_cmd;

   // attribute register, always ready
   assign csr_bus.ready = 1'b1;
   assign attr_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tmcw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // front: takes req beats and classifies them
   tmcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req        (req_bus),
      .queue_full (queue_full),
      .clearing   (clearing),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decoupling queue
   tmcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   // back: screen store, cursor, scroll sweep and rsp register
   tmcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .attribute (attr_ff),
      .clearing  (clearing),
      .rsp       (rsp_bus)
   );

endmodule
